// File: hw/rtl/adaptive_defocus_cost_filter_defines.svh
// ----------------------------------------------------------------------------
// Adaptive defocus cost filter assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_DEFOCUS_COST_FILTER_DEFINES_SVH
`define ADAPTIVE_DEFOCUS_COST_FILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ADCF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ADCF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/adcf_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive defocus cost filter package
// Constants, register codes and control structs shared by the block.
// ----------------------------------------------------------------------------
package adcf_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int MAX_SMALL_R = 3;
   localparam int MAX_LARGE_R = 7;
   localparam int FRAC_BITS   = 4;
   localparam int PIN_ROWS    = 2 * MAX_LARGE_R + 1;
   localparam int DIST_ROWS   = 2 * MAX_SMALL_R + 1;
   localparam int ROWM_W      = $clog2(PIN_ROWS);
   localparam int DROWM_W     = $clog2(DIST_ROWS);
   localparam int ROW_W       = 13;
   localparam int MAX_HEIGHT  = 4096;
   localparam int DIST_W      = 13;
   localparam int SQ_W        = 18;
   localparam int SQRT_IN_W   = SQ_W + 2 * FRAC_BITS;
   localparam int SQRT_STEPS  = SQRT_IN_W / 2;
   localparam int REM_W       = DIST_W + 2;
   localparam int NUM_W       = 19;
   localparam int GTERM_W     = 18;
   localparam int BEST_W      = 19;
   localparam int GAMMA_FRAC  = 12;
   localparam int COST_W      = 17;
   localparam logic [COST_W-1:0] COST_MAX = '1;
   localparam int ADDR_W      = 5;

   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_SMALL  = 3'd2;
   localparam logic [2:0] REG_LARGE  = 3'd3;
   localparam logic [2:0] REG_GAMMA  = 3'd4;

   typedef struct packed {
      logic [9:0]  image_width;
      logic [12:0] image_height;
      logic [1:0]  small_radius;
      logic [2:0]  large_radius;
      logic [15:0] gamma_weight;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic sqrt_pix;
      logic store_pix;
      logic sum_rd;
      logic sum_acc;
      logic div_start;
      logic def_write;
      logic ctr_rd;
      logic ctr_ld;
      logic nb_rd;
      logic nb_sq;
      logic nb_upd;
      logic fin;
      logic out_load;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic div_done;
      logic win_last;
      logic do_sum;
      logic do_cost;
      logic m_zero;
      logic rsp_busy;
   } status_type;

endpackage

// File: hw/rtl/adcf_sqrt.sv
// ----------------------------------------------------------------------------
// Adaptive defocus cost filter square root
// Bit-serial rounded square root of a scaled sum of squared differences.
// ----------------------------------------------------------------------------
module adcf_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [adcf_pkg::SQ_W-1:0]      value,
   output logic                           done,
   output logic [adcf_pkg::DIST_W-1:0]    root
);

   localparam int CNT_W = $clog2(adcf_pkg::SQRT_STEPS);

   logic [adcf_pkg::SQRT_IN_W-1:0] v_ff, v_in;
   logic [adcf_pkg::REM_W-1:0]     rem_ff, rem_in, rem_t, trial;
   logic [adcf_pkg::DIST_W-1:0]    root_ff, root_in, res_ff, res_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           busy_ff, busy_in, done_ff, done_in, ge;

   always_comb begin
      rem_t   = {rem_ff[adcf_pkg::REM_W-3:0], v_ff[adcf_pkg::SQRT_IN_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      ge      = rem_t >= trial;
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (start) begin
         v_in    = {value, {(2 * adcf_pkg::FRAC_BITS){1'b0}}};
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_t - trial : rem_t;
         root_in = {root_ff[adcf_pkg::DIST_W-2:0], ge};
         v_in    = {v_ff[adcf_pkg::SQRT_IN_W-3:0], 2'b00};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(adcf_pkg::SQRT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = root_in + adcf_pkg::DIST_W'(rem_in > {2'b00, root_in});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      res_ff  <= res_in;
   end

   assign done = done_ff;
   assign root = res_ff;

endmodule

// File: hw/rtl/adcf_datapath.sv
// ----------------------------------------------------------------------------
// Adaptive defocus cost filter datapath
// Line stores, window walker, box average divider, cost search and result.
// ----------------------------------------------------------------------------
module adcf_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  adcf_pkg::cfg_type                   cfg,
   input  logic                                cfg_wr,
   input  adcf_pkg::cmd_type                   cmd,
   output adcf_pkg::status_type                status,
   input  logic [7:0]                          refocus_red,
   input  logic [7:0]                          refocus_green,
   input  logic [7:0]                          refocus_blue,
   input  logic [7:0]                          pinhole_red,
   input  logic [7:0]                          pinhole_green,
   input  logic [7:0]                          pinhole_blue,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [adcf_pkg::COST_W-1:0]         rsp_cost,
   output logic [9:0]                          rsp_out_column,
   output logic [11:0]                         rsp_out_row,
   output logic                                rsp_last_pixel
);

   localparam int COL_W  = adcf_pkg::COL_W;
   localparam int ROWM_W = adcf_pkg::ROWM_W;
   localparam int ROW_W  = adcf_pkg::ROW_W;
   localparam int PIN_DEPTH  = adcf_pkg::PIN_ROWS * adcf_pkg::MAX_WIDTH;
   localparam int DIST_DEPTH = adcf_pkg::DIST_ROWS * adcf_pkg::MAX_WIDTH;
   localparam int PIN_AW  = ROWM_W + COL_W;
   localparam int DIST_AW = adcf_pkg::DROWM_W + COL_W;
   localparam int DIV_CNT_W = $clog2(adcf_pkg::NUM_W);
   localparam int NUMQ_W = adcf_pkg::DIST_W;
   localparam logic [ROWM_W-1:0] PIN_MOD  = ROWM_W'(adcf_pkg::PIN_ROWS);
   localparam logic [ROWM_W-1:0] DIST_MOD = ROWM_W'(adcf_pkg::DIST_ROWS);

   function automatic logic [ROWM_W-1:0] mod_sub(input logic [ROWM_W-1:0] a,
                                                  input logic [ROWM_W-1:0] k,
                                                  input logic [ROWM_W-1:0] modn);
      logic [ROWM_W:0] t;
      t = {1'b0, a} - {1'b0, k};
      if (t[ROWM_W]) begin
         t = t + {1'b0, modn};
      end
      return t[ROWM_W-1:0];
   endfunction

   function automatic logic [adcf_pkg::SQ_W-1:0] sq_sum(input logic [23:0] a,
                                                       input logic [23:0] b);
      logic [adcf_pkg::SQ_W-1:0] acc;
      logic [7:0]                d;
      acc = '0;
      for (int k = 0; k < 3; k++) begin
         d   = (a[8*k +: 8] >= b[8*k +: 8]) ? a[8*k +: 8] - b[8*k +: 8]
                                            : b[8*k +: 8] - a[8*k +: 8];
         acc = acc + adcf_pkg::SQ_W'(16'(d) * 16'(d));
      end
      return acc;
   endfunction

   // Effective geometry.
   logic [1:0]       s;
   logic [2:0]       l, m;
   logic [9:0]       w_nz;
   logic [10:0]      wlim, w_eff, pw;
   logic [12:0]      h_nz, h_eff, ph;
   logic [3:0]       lm;

   always_comb begin
      s     = cfg.small_radius;
      l     = cfg.large_radius;
      m     = (l > {1'b0, s}) ? l - {1'b0, s} : 3'd0;
      w_nz  = (cfg.image_width == '0) ? 10'd1 : cfg.image_width;
      wlim  = 11'(adcf_pkg::MAX_WIDTH) - {7'd0, l, 1'b0};
      w_eff = ({1'b0, w_nz} > wlim) ? wlim : {1'b0, w_nz};
      pw    = w_eff + {7'd0, l, 1'b0};
      h_nz  = (cfg.image_height == '0) ? 13'd1 : cfg.image_height;
      h_eff = (h_nz > 13'(adcf_pkg::MAX_HEIGHT)) ? 13'(adcf_pkg::MAX_HEIGHT) : h_nz;
      ph    = h_eff + {9'd0, l, 1'b0};
      lm    = {1'b0, l} + {1'b0, m};
   end

   // Position counters.
   logic [COL_W-1:0]            col_ff, col_in;
   logic [ROW_W-1:0]            row_ff, row_in;
   logic [ROWM_W-1:0]           rm15_ff, rm15_in;
   logic [adcf_pkg::DROWM_W-1:0] rm7_ff, rm7_in;
   logic [COL_W:0]              col_nx;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      rm15_in = rm15_ff;
      rm7_in  = rm7_ff;
      col_nx  = {1'b0, col_ff} + 1'b1;
      if (cfg_wr || (cmd.load && (({1'b0, col_ff} >= pw) || (row_ff >= ph)))) begin
         col_in  = '0;
         row_in  = '0;
         rm15_in = '0;
         rm7_in  = '0;
      end else if (cmd.advance) begin
         if (col_nx >= pw) begin
            col_in = '0;
            if ((row_ff + 1'b1) >= ph) begin
               row_in  = '0;
               rm15_in = '0;
               rm7_in  = '0;
            end else begin
               row_in  = row_ff + 1'b1;
               rm15_in = (rm15_ff == PIN_MOD - 1'b1) ? '0 : rm15_ff + 1'b1;
               rm7_in  = (rm7_ff == adcf_pkg::DROWM_W'(adcf_pkg::DIST_ROWS - 1)) ?
                         '0 : rm7_ff + 1'b1;
            end
         end else begin
            col_in = col_nx[COL_W-1:0];
         end
      end
   end

   // Pixel latch.
   logic [23:0] ref_ff, pin_ff;

   // Window walker.
   logic                 wcost_ff, wcost_in;
   logic [ROWM_W-1:0]    wrm_ff, wrm_in;
   logic [COL_W-1:0]     wcol0_ff, wcol0_in, wcol_ff, wcol_in;
   logic [3:0]           wi_ff, wi_in, wj_ff, wj_in, wn_ff, wn_in;
   logic                 win_last, win_centre;
   logic                 win_init_sum, win_init_cost, win_step;

   assign win_init_sum  = cmd.store_pix;
   assign win_init_cost = cmd.ctr_rd;
   assign win_step      = cmd.sum_acc | cmd.nb_upd;
   assign win_last      = (wi_ff == wn_ff) && (wj_ff == wn_ff);
   assign win_centre    = (wi_ff == {1'b0, m}) && (wj_ff == {1'b0, m});

   always_comb begin
      wcost_in = wcost_ff;
      wrm_in   = wrm_ff;
      wcol0_in = wcol0_ff;
      wcol_in  = wcol_ff;
      wi_in    = wi_ff;
      wj_in    = wj_ff;
      wn_in    = wn_ff;
      if (win_init_sum) begin
         wcost_in = 1'b0;
         wrm_in   = mod_sub({1'b0, rm7_ff}, {1'b0, s, 1'b0}, DIST_MOD);
         wcol0_in = col_ff - {7'd0, s, 1'b0};
         wcol_in  = wcol0_in;
         wi_in    = '0;
         wj_in    = '0;
         wn_in    = {1'b0, s, 1'b0};
      end else if (win_init_cost) begin
         wcost_in = 1'b1;
         wrm_in   = mod_sub(rm15_ff, lm, PIN_MOD);
         wcol0_in = col_ff - {6'd0, lm};
         wcol_in  = wcol0_in;
         wi_in    = '0;
         wj_in    = '0;
         wn_in    = {m, 1'b0};
      end else if (win_step) begin
         if (wj_ff == wn_ff) begin
            wj_in   = '0;
            wi_in   = wi_ff + 1'b1;
            wcol_in = wcol0_ff;
            wrm_in  = (wrm_ff == (wcost_ff ? PIN_MOD : DIST_MOD) - 1'b1) ?
                      '0 : wrm_ff + 1'b1;
         end else begin
            wj_in   = wj_ff + 1'b1;
            wcol_in = wcol_ff + 1'b1;
         end
      end
   end

   // Line stores.
   logic [23:0]               pin_mem [PIN_DEPTH];
   logic [adcf_pkg::DIST_W-1:0] dist_mem [DIST_DEPTH];
   logic [adcf_pkg::DIST_W-1:0] def_mem [PIN_DEPTH];
   logic [23:0]               pin_rd_ff;
   logic [adcf_pkg::DIST_W-1:0] dist_rd_ff, def_rd_ff;
   logic [PIN_AW-1:0]         pin_wa, pin_ra, def_wa, win_pa;
   logic [DIST_AW-1:0]        dist_wa, dist_ra;
   logic [adcf_pkg::DIST_W-1:0] sqrt_root;
   logic [NUMQ_W-1:0]         quot_unused_guard;

   assign win_pa  = {wrm_ff, wcol_ff};
   assign pin_wa  = {rm15_ff, col_ff};
   assign pin_ra  = cmd.ctr_rd ? {mod_sub(rm15_ff, {1'b0, l}, PIN_MOD), col_ff - {7'd0, l}}
                               : win_pa;
   assign def_wa  = {mod_sub(rm15_ff, {2'b00, s}, PIN_MOD), col_ff - {8'd0, s}};
   assign dist_wa = {rm7_ff, col_ff};
   assign dist_ra = {wrm_ff[adcf_pkg::DROWM_W-1:0], wcol_ff};

   // Divider.
   logic [adcf_pkg::NUM_W-1:0] acc_ff, acc_in, num_ff, num_in;
   logic [5:0]                 area, half;
   logic [6:0]                 drem_ff, drem_in, drem_t;
   logic [DIV_CNT_W-1:0]       dcnt_ff, dcnt_in;
   logic                       dbusy_ff, dbusy_in, ddone_ff, ddone_in, dge;

   always_comb begin
      case (s)
         2'd0:    begin area = 6'd1;  half = 6'd0;  end
         2'd1:    begin area = 6'd9;  half = 6'd4;  end
         2'd2:    begin area = 6'd25; half = 6'd12; end
         default: begin area = 6'd49; half = 6'd24; end
      endcase
      acc_in = acc_ff;
      if (cmd.store_pix) begin
         acc_in = '0;
      end else if (cmd.sum_acc) begin
         acc_in = acc_ff + adcf_pkg::NUM_W'(dist_rd_ff);
      end
      drem_t   = {drem_ff[5:0], num_ff[adcf_pkg::NUM_W-1]};
      dge      = drem_t >= {1'b0, area};
      num_in   = num_ff;
      drem_in  = drem_ff;
      dcnt_in  = dcnt_ff;
      dbusy_in = dbusy_ff;
      ddone_in = 1'b0;
      if (cmd.div_start) begin
         num_in   = acc_ff + adcf_pkg::NUM_W'(half);
         drem_in  = '0;
         dcnt_in  = '0;
         dbusy_in = 1'b1;
      end else if (dbusy_ff) begin
         drem_in = dge ? drem_t - {1'b0, area} : drem_t;
         num_in  = {num_ff[adcf_pkg::NUM_W-2:0], dge};
         dcnt_in = dcnt_ff + 1'b1;
         if (dcnt_ff == DIV_CNT_W'(adcf_pkg::NUM_W - 1)) begin
            dbusy_in = 1'b0;
            ddone_in = 1'b1;
         end
      end
   end

   assign quot_unused_guard = num_ff[NUMQ_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.store_pix) begin
         pin_mem[pin_wa]   <= pin_ff;
         dist_mem[dist_wa] <= sqrt_root;
      end
      if (cmd.def_write) begin
         def_mem[def_wa] <= quot_unused_guard;
      end
      pin_rd_ff  <= pin_mem[pin_ra];
      dist_rd_ff <= dist_mem[dist_ra];
      def_rd_ff  <= def_mem[win_pa];
   end

   // Square root unit, shared by pixel distance and neighbor distance.
   logic                      sqrt_start, sqrt_done;
   logic [adcf_pkg::SQ_W-1:0] sqrt_val;
   logic [23:0]               centre_ff;

   assign sqrt_start = cmd.sqrt_pix | cmd.nb_sq;
   assign sqrt_val   = cmd.nb_sq ? sq_sum(pin_rd_ff, centre_ff) : sq_sum(ref_ff, pin_ff);

   adcf_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (sqrt_val),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   // Cost search.
   logic [28:0]                    prod;
   logic [29:0]                    prod_rnd;
   logic [adcf_pkg::GTERM_W-1:0]   gterm_ff, gcentre_ff;
   logic [adcf_pkg::DIST_W-1:0]    other_ff;
   logic [adcf_pkg::BEST_W-1:0]    best_ff, tsum, csum, fmin;

   assign prod     = 29'(def_rd_ff) * 29'(cfg.gamma_weight);
   assign prod_rnd = {1'b0, prod} + 30'(1 << (adcf_pkg::GAMMA_FRAC - 1));
   assign tsum     = adcf_pkg::BEST_W'(sqrt_root) + adcf_pkg::BEST_W'(gterm_ff);
   assign csum     = adcf_pkg::BEST_W'(other_ff) + adcf_pkg::BEST_W'(gcentre_ff);
   assign fmin     = (csum < best_ff) ? csum : best_ff;

   // Result register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [adcf_pkg::COST_W-1:0] cost_ff, rcost_ff;
   logic [ROW_W-1:0]            orow;

   assign orow = row_ff - {9'd0, l, 1'b0};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         rm15_ff      <= '0;
         rm7_ff       <= '0;
         dbusy_ff     <= 1'b0;
         ddone_ff     <= 1'b0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         rm15_ff      <= rm15_in;
         rm7_ff       <= rm7_in;
         dbusy_ff     <= dbusy_in;
         ddone_ff     <= ddone_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wcost_ff <= wcost_in;
      wrm_ff   <= wrm_in;
      wcol0_ff <= wcol0_in;
      wcol_ff  <= wcol_in;
      wi_ff    <= wi_in;
      wj_ff    <= wj_in;
      wn_ff    <= wn_in;
      acc_ff   <= acc_in;
      num_ff   <= num_in;
      drem_ff  <= drem_in;
      if (cmd.load) begin
         ref_ff <= {refocus_blue, refocus_green, refocus_red};
         pin_ff <= {pinhole_blue, pinhole_green, pinhole_red};
      end
      if (cmd.ctr_ld) begin
         centre_ff <= pin_rd_ff;
      end
      if (cmd.ctr_rd) begin
         other_ff <= '1;
         best_ff  <= '1;
      end
      if (cmd.nb_sq) begin
         gterm_ff <= prod_rnd[29:adcf_pkg::GAMMA_FRAC];
      end
      if (cmd.nb_upd) begin
         if (win_centre) begin
            gcentre_ff <= gterm_ff;
         end else begin
            if (sqrt_root < other_ff) begin
               other_ff <= sqrt_root;
            end
            if (tsum < best_ff) begin
               best_ff <= tsum;
            end
         end
      end
      if (cmd.fin) begin
         if (m == 3'd0 || fmin > adcf_pkg::BEST_W'(adcf_pkg::COST_MAX)) begin
            cost_ff <= adcf_pkg::COST_MAX;
         end else begin
            cost_ff <= fmin[adcf_pkg::COST_W-1:0];
         end
      end
      if (cmd.out_load) begin
         rcost_ff       <= cost_ff;
         rsp_out_column <= col_ff - {6'd0, l, 1'b0};
         rsp_out_row    <= orow[11:0];
         rsp_last_pixel <= (row_ff == ph - 1'b1) && ({1'b0, col_ff} == pw - 1'b1);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cost  = rcost_ff;

   always_comb begin
      status.sqrt_done = sqrt_done;
      status.div_done  = ddone_ff;
      status.win_last  = win_last;
      status.do_sum    = (row_ff >= {10'd0, s, 1'b0}) && (col_ff >= {7'd0, s, 1'b0});
      status.do_cost   = (row_ff >= {9'd0, l, 1'b0}) && (col_ff >= {6'd0, l, 1'b0});
      status.m_zero    = (m == 3'd0);
      status.rsp_busy  = rsp_valid_ff && !rsp_ready;
   end

endmodule

// File: hw/rtl/adcf_ctrl.sv
// ----------------------------------------------------------------------------
// Adaptive defocus cost filter controller
// Sequences one transaction through distance, box average and cost search.
// ----------------------------------------------------------------------------
module adcf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  adcf_pkg::status_type status,
   output adcf_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_D1       = 4'd1;
   localparam logic [3:0] S_D2       = 4'd2;
   localparam logic [3:0] S_DIV_GO   = 4'd3;
   localparam logic [3:0] S_SUM_RD   = 4'd4;
   localparam logic [3:0] S_SUM_ACC  = 4'd5;
   localparam logic [3:0] S_DIV      = 4'd6;
   localparam logic [3:0] S_DEF_WR   = 4'd7;
   localparam logic [3:0] S_COST_CHK = 4'd8;
   localparam logic [3:0] S_CTR_RD   = 4'd9;
   localparam logic [3:0] S_CTR_LD   = 4'd10;
   localparam logic [3:0] S_NB_RD    = 4'd11;
   localparam logic [3:0] S_NB_SQ    = 4'd12;
   localparam logic [3:0] S_NB_WAIT  = 4'd13;
   localparam logic [3:0] S_FIN      = 4'd14;
   localparam logic [3:0] S_OUT      = 4'd15;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_D1;
            end
         end
         S_D1: begin
            cmd.sqrt_pix = 1'b1;
            state_in     = S_D2;
         end
         S_D2: begin
            if (status.sqrt_done) begin
               cmd.store_pix = 1'b1;
               state_in      = status.do_sum ? S_SUM_RD : S_COST_CHK;
            end
         end
         S_SUM_RD: begin
            cmd.sum_rd = 1'b1;
            state_in   = S_SUM_ACC;
         end
         S_SUM_ACC: begin
            cmd.sum_acc = 1'b1;
            state_in    = status.win_last ? S_DIV_GO : S_SUM_RD;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_DEF_WR;
            end
         end
         S_DEF_WR: begin
            cmd.def_write = 1'b1;
            state_in      = S_COST_CHK;
         end
         S_COST_CHK: begin
            if (!status.do_cost) begin
               state_in = S_OUT;
            end else if (status.m_zero) begin
               state_in = S_FIN;
            end else begin
               state_in = S_CTR_RD;
            end
         end
         S_CTR_RD: begin
            cmd.ctr_rd = 1'b1;
            state_in   = S_CTR_LD;
         end
         S_CTR_LD: begin
            cmd.ctr_ld = 1'b1;
            state_in   = S_NB_RD;
         end
         S_NB_RD: begin
            cmd.nb_rd = 1'b1;
            state_in  = S_NB_SQ;
         end
         S_NB_SQ: begin
            cmd.nb_sq = 1'b1;
            state_in  = S_NB_WAIT;
         end
         S_NB_WAIT: begin
            if (status.sqrt_done) begin
               cmd.nb_upd = 1'b1;
               state_in   = status.win_last ? S_FIN : S_NB_RD;
            end
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!status.do_cost) begin
               cmd.advance = 1'b1;
               state_in    = S_IDLE;
            end else if (!status.rsp_busy) begin
               cmd.out_load = 1'b1;
               cmd.advance  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// File: hw/rtl/adcf_csr.sv
// ----------------------------------------------------------------------------
// Adaptive defocus cost filter registers
// APB-style configuration registers with readback.
// ----------------------------------------------------------------------------
module adcf_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [adcf_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output adcf_pkg::cfg_type             cfg,
   output logic                          cfg_wr
);

   adcf_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        idx;
   logic              wr, hit;

   assign idx = paddr[adcf_pkg::ADDR_W-1:2];
   assign wr  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      hit    = 1'b1;
      prdata = '0;
      unique case (idx)
         adcf_pkg::REG_WIDTH: begin
            prdata = {22'd0, cfg_ff.image_width};
            if (wr) cfg_in.image_width = pwdata[9:0];
         end
         adcf_pkg::REG_HEIGHT: begin
            prdata = {19'd0, cfg_ff.image_height};
            if (wr) cfg_in.image_height = pwdata[12:0];
         end
         adcf_pkg::REG_SMALL: begin
            prdata = {30'd0, cfg_ff.small_radius};
            if (wr) cfg_in.small_radius = pwdata[1:0];
         end
         adcf_pkg::REG_LARGE: begin
            prdata = {29'd0, cfg_ff.large_radius};
            if (wr) cfg_in.large_radius = pwdata[2:0];
         end
         adcf_pkg::REG_GAMMA: begin
            prdata = {16'd0, cfg_ff.gamma_weight};
            if (wr) cfg_in.gamma_weight = pwdata[15:0];
         end
         default: hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= 10'd64;
         cfg_ff.image_height <= 13'd64;
         cfg_ff.small_radius <= 2'd1;
         cfg_ff.large_radius <= 3'd3;
         cfg_ff.gamma_weight <= 16'd4096;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg    = cfg_ff;
   assign cfg_wr = wr && hit;
   assign pready = 1'b1;

endmodule

// File: hw/rtl/adaptive_defocus_cost_filter.sv
// ----------------------------------------------------------------------------
// Adaptive defocus cost filter
// Per-pixel defocus-weighted pinhole distance cost over padded raster input.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  refocus and pinhole RGB bytes
//   rsp      out        rsp_valid/rsp_ready  cost, column, row, last pixel
//   csr      in         APB-style            five configuration registers
//
// A transaction inside both windows is dominated by the shared bit-serial square
// root walked over the medium window.
// Reset is synchronous and active high; it restores the register defaults.
// The next transaction is taken while a result waits in the output register;
// a result finding that register still full waits for rsp_ready.
// ----------------------------------------------------------------------------
module adaptive_defocus_cost_filter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [adcf_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_refocus_red,
   input  logic [7:0]                  req_refocus_green,
   input  logic [7:0]                  req_refocus_blue,
   input  logic [7:0]                  req_pinhole_red,
   input  logic [7:0]                  req_pinhole_green,
   input  logic [7:0]                  req_pinhole_blue,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [16:0]                 rsp_cost,
   output logic [9:0]                  rsp_out_column,
   output logic [11:0]                 rsp_out_row,
   output logic                        rsp_last_pixel
);

   adcf_pkg::cfg_type    cfg;
   adcf_pkg::cmd_type    cmd;
   adcf_pkg::status_type status;
   logic                 cfg_wr;

   adcf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .cfg_wr  (cfg_wr)
   );

   adcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   adcf_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cfg_wr         (cfg_wr),
      .cmd            (cmd),
      .status         (status),
      .refocus_red    (req_refocus_red),
      .refocus_green  (req_refocus_green),
      .refocus_blue   (req_refocus_blue),
      .pinhole_red    (req_pinhole_red),
      .pinhole_green  (req_pinhole_green),
      .pinhole_blue   (req_pinhole_blue),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_cost       (rsp_cost),
      .rsp_out_column (rsp_out_column),
      .rsp_out_row    (rsp_out_row),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule

// File: hw/rtl/adcf_checker.sv
// ----------------------------------------------------------------------------
// Adaptive defocus cost filter checker
// Port-level assertions on handshake behavior, bound to the top level.
// ----------------------------------------------------------------------------
`include "adaptive_defocus_cost_filter_defines.svh"

module adcf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   `ADCF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `ADCF_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, !rsp_valid && req_ready, "bad state after reset")
   `ADCF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready right after a transaction")

endmodule

bind adaptive_defocus_cost_filter adcf_checker u_adcf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);

// File: tb/tb_adaptive_defocus_cost_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive defocus cost filter testbench
// Streams padded refocused/pinhole pixel frames through the filter under many
// register settings, predicts every cost result in the bench and compares each
// returned transaction field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_adaptive_defocus_cost_filter;

   localparam int ADDR_W     = adcf_pkg::ADDR_W;
   localparam int MAX_WIDTH  = adcf_pkg::MAX_WIDTH;
   localparam int MAX_HEIGHT = adcf_pkg::MAX_HEIGHT;
   localparam int PIN_ROWS   = adcf_pkg::PIN_ROWS;
   localparam int DIST_ROWS  = adcf_pkg::DIST_ROWS;
   localparam int FRAC_BITS  = adcf_pkg::FRAC_BITS;
   localparam int GAMMA_FRAC = adcf_pkg::GAMMA_FRAC;
   localparam logic [16:0] COST_MAX = adcf_pkg::COST_MAX;
   localparam logic [2:0] REG_SPARE = 3'd6;
   localparam int TARGET_PIXELS = 1450;

   typedef struct packed {
      logic [7:0] ref_red;
      logic [7:0] ref_green;
      logic [7:0] ref_blue;
      logic [7:0] pin_red;
      logic [7:0] pin_green;
      logic [7:0] pin_blue;
   } pixel_pair_type;

   typedef struct packed {
      logic [16:0] cost;
      logic [9:0]  column;
      logic [11:0] row;
      logic        last;
   } cost_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;
   logic req_valid = 1'b0;
   logic req_ready;
   pixel_pair_type req_pixel = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [16:0] rsp_cost;
   logic [9:0] rsp_out_column;
   logic [11:0] rsp_out_row;
   logic rsp_last_pixel;

   adaptive_defocus_cost_filter DUT (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_refocus_red(req_pixel.ref_red), .req_refocus_green(req_pixel.ref_green),
      .req_refocus_blue(req_pixel.ref_blue), .req_pinhole_red(req_pixel.pin_red),
      .req_pinhole_green(req_pixel.pin_green), .req_pinhole_blue(req_pixel.pin_blue),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_cost(rsp_cost),
      .rsp_out_column(rsp_out_column), .rsp_out_row(rsp_out_row),
      .rsp_last_pixel(rsp_last_pixel)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Bench copy of the configuration and line stores.
   logic [9:0]  cfg_width = 10'd64;
   logic [12:0] cfg_height = 13'd64;
   logic [1:0]  cfg_small = 2'd1;
   logic [2:0]  cfg_large = 3'd3;
   logic [15:0] cfg_gamma = 16'd4096;
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;
   logic [23:0] pin_mem [PIN_ROWS*MAX_WIDTH];
   logic [12:0] dist_mem [DIST_ROWS*MAX_WIDTH];
   logic [12:0] def_mem [PIN_ROWS*MAX_WIDTH];

   pixel_pair_type pixel_q[$];
   cost_result_type cost_q[$];
   int pixels_sent = 0;
   int pixels_taken = 0;
   int results_seen = 0;
   int config_writes = 0;
   int mismatches = 0;

   function automatic int unsigned color_distance(logic [23:0] a, logic [23:0] b);
      longint unsigned sq, v, q, bit_v;
      int d;
      sq = 0;
      for (int k = 0; k < 3; k++) begin
         d = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
         sq += longint'(d * d);
      end
      v = sq << (2 * FRAC_BITS);
      sq = v;
      q = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > sq) bit_v >>= 2;
      while (bit_v != 0) begin
         if (sq >= q + bit_v) begin
            sq -= q + bit_v;
            q = (q >> 1) + bit_v;
         end else begin
            q >>= 1;
         end
         bit_v >>= 2;
      end
      if (v > q * q + q) q++;
      return int'(q);
   endfunction

   function automatic void frame_geometry(output int unsigned w, output int unsigned h,
                                          output int unsigned s, output int unsigned l,
                                          output int unsigned m);
      s = cfg_small;
      l = cfg_large;
      w = (cfg_width == 0) ? 1 : cfg_width;
      if (w > MAX_WIDTH - 2 * l) w = MAX_WIDTH - 2 * l;
      h = (cfg_height == 0) ? 1 : cfg_height;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      m = (l > s) ? l - s : 0;
   endfunction

   task automatic predict_cost(input pixel_pair_type px);
      int unsigned w, h, s, l, m, pw, ph, r, c, area, cy, cx, other, ck, k, d;
      int unsigned centre_idx;
      int unsigned nd [225];
      longint unsigned sum, best, t, defv;
      logic [23:0] refc, pinc;
      cost_result_type res;
      frame_geometry(w, h, s, l, m);
      pw = w + 2 * l;
      ph = h + 2 * l;
      r = row_pos;
      c = col_pos;
      if (c >= pw || r >= ph) begin
         r = 0;
         c = 0;
      end
      refc = {px.ref_blue, px.ref_green, px.ref_red};
      pinc = {px.pin_blue, px.pin_green, px.pin_red};
      pin_mem[(r % PIN_ROWS) * MAX_WIDTH + c] = pinc;
      dist_mem[(r % DIST_ROWS) * MAX_WIDTH + c] = 13'(color_distance(refc, pinc));
      if (r >= 2 * s && c >= 2 * s) begin
         area = (2 * s + 1) * (2 * s + 1);
         sum = 0;
         for (int unsigned i = r - 2 * s; i <= r; i++)
            for (int unsigned j = c - 2 * s; j <= c; j++)
               sum += dist_mem[(i % DIST_ROWS) * MAX_WIDTH + j];
         def_mem[((r - s) % PIN_ROWS) * MAX_WIDTH + c - s] = 13'((sum + area / 2) / area);
      end
      if (r >= 2 * l && c >= 2 * l) begin
         cy = r - l;
         cx = c - l;
         res.cost = COST_MAX;
         if (m > 0) begin
            centre_idx = (cy % PIN_ROWS) * MAX_WIDTH + cx;
            other = 32'hFFFF_FFFF;
            k = 0;
            ck = 0;
            for (int unsigned i = cy - m; i <= cy + m; i++)
               for (int unsigned j = cx - m; j <= cx + m; j++) begin
                  d = color_distance(pin_mem[(i % PIN_ROWS) * MAX_WIDTH + j],
                                     pin_mem[centre_idx]);
                  if (i == cy && j == cx) ck = k;
                  else if (d < other) other = d;
                  nd[k] = d;
                  k++;
               end
            nd[ck] = other;
            k = 0;
            best = 64'hFFFF_FFFF_FFFF_FFFF;
            for (int unsigned i = cy - m; i <= cy + m; i++)
               for (int unsigned j = cx - m; j <= cx + m; j++) begin
                  defv = def_mem[(i % PIN_ROWS) * MAX_WIDTH + j];
                  t = longint'(nd[k]) + ((defv * cfg_gamma + 2048) >> GAMMA_FRAC);
                  k++;
                  if (t < best) best = t;
               end
            res.cost = (best > COST_MAX) ? COST_MAX : 17'(best);
         end
         res.column = 10'(c - 2 * l);
         res.row = 12'(r - 2 * l);
         res.last = (r == ph - 1 && c == pw - 1);
         cost_q.push_back(res);
      end
      c++;
      if (c >= pw) begin
         c = 0;
         r++;
         if (r >= ph) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   // Pixel driver.
   int send_gap = 0;
   bit send_burst = 0;
   always @(posedge clock) begin
      pixel_pair_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_cost(req_pixel);
            pixels_taken++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
               nxt = pixel_q.pop_front();
               req_pixel <= nxt;
               req_valid <= 1'b1;
               if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
               send_gap = send_burst ? 0 : $urandom_range(0, 9);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor.
   int recv_stall = 0;
   bit recv_burst = 0;
   always @(posedge clock) begin
      cost_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (cost_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result: cost %0d column %0d row %0d last %0b",
                           rsp_cost, rsp_out_column, rsp_out_row, rsp_last_pixel);
            end else begin
               want = cost_q.pop_front();
               if (rsp_cost !== want.cost || rsp_out_column !== want.column ||
                   rsp_out_row !== want.row || rsp_last_pixel !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"Mismatch: expected cost %0d column %0d row %0d last %0b,",
                               " got cost %0d column %0d row %0d last %0b"},
                              want.cost, want.column, want.row, want.last,
                              rsp_cost, rsp_out_column, rsp_out_row, rsp_last_pixel);
               end
            end
            if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
            recv_stall = recv_burst ? 0 : $urandom_range(0, 9);
         end
         if (recv_stall > 0) recv_stall--;
         rsp_ready <= (recv_stall == 0);
      end
   end

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      config_writes++;
      case (index)
         adcf_pkg::REG_WIDTH:  cfg_width = value[9:0];
         adcf_pkg::REG_HEIGHT: cfg_height = value[12:0];
         adcf_pkg::REG_SMALL:  cfg_small = value[1:0];
         adcf_pkg::REG_LARGE:  cfg_large = value[2:0];
         adcf_pkg::REG_GAMMA:  cfg_gamma = value[15:0];
         default:              return;
      endcase
      col_pos = 0;
      row_pos = 0;
   endtask

   task automatic configure(input int w, input int h, input int s, input int l, input int g);
      csr_write(adcf_pkg::REG_WIDTH, w);
      csr_write(adcf_pkg::REG_HEIGHT, h);
      csr_write(adcf_pkg::REG_SMALL, s);
      csr_write(adcf_pkg::REG_LARGE, l);
      csr_write(adcf_pkg::REG_GAMMA, g);
   endtask

   // Waits until every pixel is taken and every result is back, then lets a
   // pixel that makes no result finish its window walk.
   task automatic drain();
      int unsigned w, h, s, l, m;
      while (pixel_q.size() > 0 || req_valid || cost_q.size() > 0) @(posedge clock);
      frame_geometry(w, h, s, l, m);
      repeat (80 + 2 * (2 * s + 1) ** 2 + 16 * (2 * m + 1) ** 2) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_byte(input logic [7:0] near);
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         2, 3: return near + 8'($urandom_range(0, 15)) - 8'd8;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic queue_random(input int count);
      pixel_pair_type px;
      for (int i = 0; i < count; i++) begin
         px.pin_red = rand_byte(8'h80);
         px.pin_green = rand_byte(8'h40);
         px.pin_blue = rand_byte(8'hC0);
         px.ref_red = rand_byte(px.pin_red);
         px.ref_green = rand_byte(px.pin_green);
         px.ref_blue = rand_byte(px.pin_blue);
         pixel_q.push_back(px);
         pixels_sent++;
      end
   endtask

   task automatic queue_pixel(input logic [23:0] refc, input logic [23:0] pinc);
      pixel_q.push_back({refc, pinc});
      pixels_sent++;
   endtask

   initial begin
      int w, h, s, l, g, frames;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero sizes act as one pixel; a 3x3 padded frame with one result.
      configure(0, 0, 0, 1, 4096);
      queue_pixel(24'h000000, 24'hFFFFFF);
      queue_pixel(24'hFFFFFF, 24'h000000);
      queue_pixel(24'hFFFFFF, 24'hFFFFFF);
      queue_pixel(24'h000000, 24'h000000);
      queue_pixel(24'h123456, 24'h123456);
      queue_pixel(24'hFF0000, 24'h00FF00);
      queue_pixel(24'h0000FF, 24'hFFFF00);
      queue_pixel(24'h808080, 24'h7F7F7F);
      queue_pixel(24'h010203, 24'hFEFDFC);
      drain();
      // Empty medium window: small radius reaches the large radius.
      configure(2, 2, 1, 1, 65535);
      for (int i = 0; i < 16; i++)
         queue_pixel(i[0] ? 24'hFFFFFF : 24'h000000, i[1] ? 24'h000000 : 24'hFFFFFF);
      drain();
      // A write to an unused index leaves the frame position alone.
      configure(1, 1, 0, 1, 0);
      queue_random(4);
      drain();
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      queue_random(14);
      drain();
      // Largest radii over a single output pixel.
      configure(1, 1, 3, 7, 65535);
      queue_random(225);
      drain();
      // Oversize width is clamped; partial frames with the widest windows.
      configure(1023, 8191, 0, 7, 4096);
      queue_random(30);
      drain();
      configure(1010, 4096, 3, 1, 12345);
      queue_random(40);
      drain();

      while (pixels_sent < TARGET_PIXELS) begin
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 3);
         l = $urandom_range(1, 3);
         s = $urandom_range(0, 3);
         if ($urandom_range(0, 7) == 0) begin
            l = $urandom_range(4, 5);
            s = 3;
            w = 1;
         end
         case ($urandom_range(0, 3))
            0: g = 0;
            1: g = 65535;
            2: g = $urandom_range(0, 8192);
            default: g = $urandom_range(0, 65535);
         endcase
         configure(w, h, s, l, g);
         frames = $urandom_range(1, 2);
         if ($urandom_range(0, 5) == 0)
            queue_random($urandom_range(1, (w + 2 * l) * (h + 2 * l) * 2 - 1));
         else
            queue_random(frames * (w + 2 * l) * (h + 2 * l));
         drain();
      end

      $display("Covered %0d pixel transactions and %0d cost results over %0d register writes.",
               pixels_taken, results_seen, config_writes);
      if (mismatches == 0 && cost_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Mismatches: %0d, results still expected: %0d", mismatches, cost_q.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
